// ----- sv/pfba_pkg.sv -----
// ----------------------------------------------------------------------------
// pfba_pkg
// shared constants, codes and types of the page frame bitmap allocator
// ----------------------------------------------------------------------------
package pfba_pkg;

    // bitmap geometry
    localparam int MAP_WORDS  = 1024;
    localparam int WORD_BITS  = 64;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int MAP_AW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CAP_FRAMES = MAP_WORDS * WORD_BITS;

    // field widths
    localparam int FRAME_W = 16;
    localparam int COUNT_W = 17;

    localparam logic [COUNT_W-1:0] FRAME_LIMIT   = 17'h10000;
    localparam logic [COUNT_W-1:0] MANAGED_RESET = 17'h10000;

    typedef enum logic [1:0] {
        MODE_ALLOC_RUN   = 2'd0,
        MODE_ALLOC_ONE   = 2'd1,
        MODE_FREE_RUN    = 2'd2,
        MODE_RESERVE_RUN = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

    // outcome of scanning one bitmap word
    typedef struct packed {
        logic               hit;
        logic [BIT_W-1:0]   pos;
        logic [COUNT_W-1:0] run_out;
    } scan_res_t;

    // run of frames to be set or cleared, stop is exclusive
    typedef struct packed {
        logic [FRAME_W-1:0] first;
        logic [COUNT_W-1:0] stop;
    } run_t;

endpackage

// ----- sv/page_frame_bitmap_allocator.sv -----
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator
// one used bit per page frame, allocate, free and reserve runs of frames
// ----------------------------------------------------------------------------
// after reset a clearing pass writes zeros over all 1024 bitmap words,
// with no request taken meanwhile; managed_frames resets to 65536
// allocate: a scan of the bitmap words, then a read-modify-write of the words
// of the run found, the bitmap ram read port walking one word per cycle
// free or reserve: read-modify-write of the words touched; one request in flight at a time,
// the next request is taken while the previous result waits in the output register
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator (
    input  logic                          clk,
    input  logic                          rst_n,

    // managed_frames register
    input  logic                          cfg_wr_en,
    input  logic [pfba_pkg::COUNT_W-1:0]  cfg_wr_data,

    // request: tdata = start_frame[15:0], count[32:16], zero pad [39:33]
    //          tuser = mode[1:0]
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [39:0]                   s_axis_tdata,
    input  logic [1:0]                    s_axis_tuser,

    // result: tdata = frame[15:0], ok[16], zero pad [23:17]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [23:0]                   m_axis_tdata
);
    import pfba_pkg::*;

    localparam int OUT_PAD = 24 - FRAME_W - 1;

    // control registers
    state_t             state_reg, state_next;
    logic [MAP_AW:0]    ptr_reg, ptr_next;         // extra bit marks end of range
    logic               dvalid_reg, dvalid_next;   // ram read data is live
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] managed_reg, managed_next;

    // payload registers
    logic [MAP_AW-1:0]  dword_reg, dword_next;     // word index of ram read data
    logic [COUNT_W-1:0] cnt_reg, cnt_next;         // run length searched for
    logic [COUNT_W-1:0] run_reg, run_next;         // free run carried across words
    run_t               run_desc_reg, run_desc_next;
    logic               set_reg, set_next;         // 1 marks used, 0 frees
    logic [FRAME_W-1:0] res_frame_reg, res_frame_next;
    logic               res_ok_reg, res_ok_next;
    logic [FRAME_W-1:0] out_frame_reg, out_frame_next;
    logic               out_ok_reg, out_ok_next;

    // request fields
    mode_t              in_mode;
    logic [FRAME_W-1:0] in_start;
    logic [COUNT_W-1:0] in_count;
    logic [COUNT_W-1:0] in_eff_count;
    logic [COUNT_W:0]   in_sum;
    logic [COUNT_W-1:0] in_stop;
    logic               in_fire;
    logic               in_alloc;
    logic               in_fail;
    logic               in_empty;

    // search bound
    logic [COUNT_W-1:0] lim_frames;
    logic [COUNT_W-1:0] search_lim;
    logic [MAP_AW-1:0]  scan_last_word;
    logic [MAP_AW-1:0]  write_last_word;

    // sequencer conditions
    logic               issue_scan;
    logic               issue_write;
    logic               scan_last;
    logic               write_last;
    logic               clear_last;
    logic               out_free;
    logic [COUNT_W-1:0] found_stop;
    logic [COUNT_W-1:0] found_first;

    // ram and shared units
    logic                 ram_we;
    logic [MAP_AW-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] wmask;
    logic [WORD_BITS-1:0] merged;
    scan_res_t            scan_res;

    // ------------------------------------------------------------------
    // request decode
    // ------------------------------------------------------------------
    assign in_mode      = mode_t'(s_axis_tuser);
    assign in_start     = s_axis_tdata[FRAME_W-1:0];
    assign in_count     = s_axis_tdata[FRAME_W+COUNT_W-1:FRAME_W];
    assign in_fire      = s_axis_tvalid && s_axis_tready;
    assign in_alloc     = (in_mode == MODE_ALLOC_RUN) || (in_mode == MODE_ALLOC_ONE);
    // single frame allocation is a run of one
    assign in_eff_count = (in_mode == MODE_ALLOC_ONE) ? COUNT_W'(1) : in_count;
    assign in_fail      = (in_eff_count == '0) || (search_lim == '0);
    // free and reserve stop at the end of the bitmap
    assign in_sum       = (COUNT_W+1)'(in_start) + (COUNT_W+1)'(in_count);
    assign in_stop      = (32'(in_sum) > 32'(CAP_FRAMES)) ? COUNT_W'(CAP_FRAMES) :
                          in_sum[COUNT_W-1:0];
    assign in_empty     = (in_stop <= COUNT_W'(in_start));

    // search bound is the smallest of managed_frames, map capacity, frame limit
    assign lim_frames = (managed_reg > FRAME_LIMIT) ? FRAME_LIMIT : managed_reg;
    assign search_lim = (32'(lim_frames) > 32'(CAP_FRAMES)) ?
                        COUNT_W'(CAP_FRAMES) : lim_frames;

    assign scan_last_word  = MAP_AW'((search_lim - COUNT_W'(1)) >> BIT_W);
    assign write_last_word = MAP_AW'((run_desc_reg.stop - COUNT_W'(1)) >> BIT_W);

    assign issue_scan  = (ptr_reg <= {1'b0, scan_last_word});
    assign issue_write = (ptr_reg <= {1'b0, write_last_word});
    assign scan_last   = (dword_reg == scan_last_word);
    assign write_last  = (dword_reg == write_last_word);
    assign clear_last  = (ptr_reg[MAP_AW-1:0] == MAP_AW'(MAP_WORDS - 1));
    assign out_free    = !out_valid_reg || m_axis_tready;

    // run found ends at the hit position of the current word
    assign found_stop  = COUNT_W'({dword_reg, scan_res.pos}) + COUNT_W'(1);
    assign found_first = found_stop - cnt_reg;

    assign merged = set_reg ? (ram_rdata | wmask) : (ram_rdata & ~wmask);

    // ------------------------------------------------------------------
    // bitmap memory and word units
    // ------------------------------------------------------------------
    pfba_map_ram #(
        .DEPTH (MAP_WORDS),
        .WIDTH (WORD_BITS)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ptr_reg[MAP_AW-1:0]),
        .rdata (ram_rdata)
    );

    pfba_word_scan u_word_scan (
        .word       (ram_rdata),
        .word_idx   (dword_reg),
        .search_lim (search_lim),
        .cnt        (cnt_reg),
        .run_in     (run_reg),
        .res        (scan_res)
    );

    pfba_run_mask u_run_mask (
        .word_idx (dword_reg),
        .run      (run_desc_reg),
        .mask     (wmask)
    );

    // ------------------------------------------------------------------
    // sequencer next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_alloc)
                    begin
                        state_next = in_fail ? ST_DONE : ST_SCAN;
                    end
                    else
                    begin
                        state_next = in_empty ? ST_DONE : ST_WRITE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (dvalid_reg)
                begin
                    if (scan_res.hit)
                    begin
                        state_next = ST_WRITE;
                    end
                    else if (scan_last)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_WRITE:
            begin
                if (dvalid_reg && write_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer outputs and datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        ptr_next       = ptr_reg;
        dvalid_next    = 1'b0;
        dword_next     = dword_reg;
        cnt_next       = cnt_reg;
        run_next       = run_reg;
        run_desc_next  = run_desc_reg;
        set_next       = set_reg;
        res_frame_next = res_frame_reg;
        res_ok_next    = res_ok_reg;
        ram_we         = 1'b0;
        ram_waddr      = dword_reg;
        ram_wdata      = merged;
        ram_re         = 1'b0;

        // output register drains independently of the sequencer
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_frame_next = out_frame_reg;
        out_ok_next    = out_ok_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // zero one word per cycle
                ram_we    = 1'b1;
                ram_waddr = ptr_reg[MAP_AW-1:0];
                ram_wdata = '0;
                ptr_next  = clear_last ? '0 : ptr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cnt_next = in_eff_count;
                    run_next = '0;
                    set_next = (in_mode != MODE_FREE_RUN);
                    if (in_alloc)
                    begin
                        ptr_next       = '0;
                        res_frame_next = '0;
                        res_ok_next    = 1'b0;
                    end
                    else
                    begin
                        run_desc_next.first = in_start;
                        run_desc_next.stop  = in_stop;
                        res_frame_next      = in_start;
                        res_ok_next         = 1'b1;
                        ptr_next            = {1'b0, MAP_AW'(in_start >> BIT_W)};
                    end
                end
            end
            ST_SCAN:
            begin
                // read ahead one word while the previous one is scanned
                ram_re      = issue_scan;
                dvalid_next = issue_scan;
                dword_next  = ptr_reg[MAP_AW-1:0];
                if (issue_scan)
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                if (dvalid_reg)
                begin
                    if (scan_res.hit)
                    begin
                        // drop the read in flight and claim the run
                        dvalid_next         = 1'b0;
                        run_desc_next.first = found_first[FRAME_W-1:0];
                        run_desc_next.stop  = found_stop;
                        res_frame_next      = found_first[FRAME_W-1:0];
                        res_ok_next         = 1'b1;
                        ptr_next            = {1'b0, MAP_AW'(found_first >> BIT_W)};
                    end
                    else
                    begin
                        run_next = scan_res.run_out;
                    end
                end
            end
            ST_WRITE:
            begin
                // read-modify-write, next read overlaps current write
                ram_re      = issue_write;
                dvalid_next = issue_write;
                dword_next  = ptr_reg[MAP_AW-1:0];
                if (issue_write)
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                ram_we = dvalid_reg;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_frame_next = res_frame_reg;
                    out_ok_next    = res_ok_reg;
                end
            end
            default:
            begin
                ptr_next = ptr_reg;
            end
        endcase
    end

    assign managed_next = cfg_wr_en ? cfg_wr_data : managed_reg;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ptr_reg       <= '0;
            dvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            managed_reg   <= MANAGED_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            dvalid_reg    <= dvalid_next;
            out_valid_reg <= out_valid_next;
            managed_reg   <= managed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dword_reg     <= dword_next;
        cnt_reg       <= cnt_next;
        run_reg       <= run_next;
        run_desc_reg  <= run_desc_next;
        set_reg       <= set_next;
        res_frame_reg <= res_frame_next;
        res_ok_reg    <= res_ok_next;
        out_frame_reg <= out_frame_next;
        out_ok_reg    <= out_ok_next;
    end

    // ------------------------------------------------------------------
    // ports
    // ------------------------------------------------------------------
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_ok_reg, out_frame_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // bitmap is only written by clearing or by a request in progress
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !ram_we)
        else $error("bitmap written while idle");

    // carried run never reaches the wanted length without a hit
    a_run_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (run_reg < cnt_reg))
        else $error("carried run reached count during scan");

    // every word visited by a run write holds at least one bit of the run
    a_write_touches_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE && dvalid_reg) |-> (wmask != '0))
        else $error("run write on a word outside the run");

    // an accepted request always leaves idle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg != ST_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // failed results carry frame zero
    a_fail_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !out_ok_reg) |-> (out_frame_reg == '0))
        else $error("failed result with nonzero frame");

endmodule

// ----- sv/pfba_map_ram.sv -----
// ----------------------------------------------------------------------------
// pfba_map_ram
// one write port, one read port memory with registered read data
// ----------------------------------------------------------------------------
module pfba_map_ram #(
    parameter  int DEPTH = 1024,
    parameter  int WIDTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/pfba_word_scan.sv -----
// ----------------------------------------------------------------------------
// pfba_word_scan
// finds the lowest frame of one bitmap word that completes a free run
// ----------------------------------------------------------------------------
module pfba_word_scan (
    input  logic [pfba_pkg::WORD_BITS-1:0] word,
    input  logic [pfba_pkg::MAP_AW-1:0]    word_idx,
    input  logic [pfba_pkg::COUNT_W-1:0]   search_lim,
    input  logic [pfba_pkg::COUNT_W-1:0]   cnt,
    input  logic [pfba_pkg::COUNT_W-1:0]   run_in,
    output pfba_pkg::scan_res_t            res
);
    import pfba_pkg::*;

    localparam int LU_W = BIT_W + 1;

    logic [WORD_BITS-1:0] bound_mask;
    logic [WORD_BITS-1:0] used;
    logic [COUNT_W-1:0]   need;
    logic                 cnt_small;
    logic [LU_W-1:0]      lu [BIT_W+1][WORD_BITS];
    logic [WORD_BITS-1:0] hit_vec;
    logic [BIT_W-1:0]     pos;

    // frames at or above the search bound read as used
    assign bound_mask = ((search_lim[BIT_W-1:0] != '0) &&
                         (word_idx == MAP_AW'(search_lim >> BIT_W))) ?
                        ~(({{(WORD_BITS-1){1'b0}}, 1'b1} << search_lim[BIT_W-1:0])
                          - {{(WORD_BITS-1){1'b0}}, 1'b1}) : '0;
    assign used      = word | bound_mask;
    assign need      = cnt - run_in;
    assign cnt_small = (cnt <= COUNT_W'(WORD_BITS));

    always_comb
    begin
        int src;
        src = 0;
        // lu holds one plus the highest used bit at or below each position
        for (int p = 0; p < WORD_BITS; p++)
        begin
            lu[0][p] = used[p] ? LU_W'(p + 1) : '0;
        end
        for (int j = 0; j < BIT_W; j++)
        begin
            for (int p = 0; p < WORD_BITS; p++)
            begin
                src = (p >= (1 << j)) ? p - (1 << j) : p;
                lu[j+1][p] = (lu[j][p] == '0) ? lu[j][src] : lu[j][p];
            end
        end
        for (int p = 0; p < WORD_BITS; p++)
        begin
            if (lu[BIT_W][p] == '0)
            begin
                // run carried in from earlier words
                hit_vec[p] = !used[p] && (need <= COUNT_W'(p + 1));
            end
            else
            begin
                hit_vec[p] = !used[p] && cnt_small &&
                             ((LU_W'(p + 1) - lu[BIT_W][p]) >= cnt[LU_W-1:0]);
            end
        end
        pos = '0;
        for (int p = WORD_BITS - 1; p >= 0; p--)
        begin
            if (hit_vec[p])
            begin
                pos = BIT_W'(p);
            end
        end
    end

    assign res.hit     = |hit_vec;
    assign res.pos     = pos;
    assign res.run_out = (lu[BIT_W][WORD_BITS-1] == '0) ?
                         (run_in + COUNT_W'(WORD_BITS)) :
                         COUNT_W'(LU_W'(WORD_BITS) - lu[BIT_W][WORD_BITS-1]);

endmodule

// ----- sv/pfba_run_mask.sv -----
// ----------------------------------------------------------------------------
// pfba_run_mask
// bits of one bitmap word that lie inside a run of frames
// ----------------------------------------------------------------------------
module pfba_run_mask (
    input  logic [pfba_pkg::MAP_AW-1:0]    word_idx,
    input  pfba_pkg::run_t                 run,
    output logic [pfba_pkg::WORD_BITS-1:0] mask
);
    import pfba_pkg::*;

    logic [COUNT_W-1:0]   last_frame;
    logic [MAP_AW-1:0]    first_word;
    logic [MAP_AW-1:0]    last_word;
    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] hi_mask;

    assign last_frame = run.stop - COUNT_W'(1);
    assign first_word = MAP_AW'(run.first >> BIT_W);
    assign last_word  = MAP_AW'(last_frame >> BIT_W);

    assign lo_mask = (word_idx == first_word) ?
                     ({WORD_BITS{1'b1}} << run.first[BIT_W-1:0]) : '1;
    assign hi_mask = (word_idx == last_word) ?
                     ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - last_frame[BIT_W-1:0])) :
                     '1;
    assign mask    = lo_mask & hi_mask;

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// checks the page frame bitmap allocator against a frame-by-frame bitmap kept
// here: a directed table of corner requests first, then phases of random
// requests, each phase under its own managed_frames setting
// ----------------------------------------------------------------------------
module tb;

    import pfba_pkg::*;

    localparam int DIRECTED_ROWS = 24;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 54;
    localparam int IDLE_PCT      = 36;

    // one request, with its result typed in where it is plain to see
    typedef struct packed {
        mode_t              mode;
        logic [FRAME_W-1:0] start;
        logic [COUNT_W-1:0] count;
        logic               known;
        logic [FRAME_W-1:0] frame;
        logic               ok;
    } request_row_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               ok;
    } grant_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [COUNT_W-1:0] cfg_wr_data = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [39:0]        s_axis_tdata = '0;   // start_frame[15:0], count[32:16], pad
    logic [1:0]         s_axis_tuser = '0;   // mode[1:0]
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [23:0]        m_axis_tdata;        // frame[15:0], ok[16], pad

    // frame bitmap as this bench sees it, one flag per frame
    bit                 frame_busy [CAP_FRAMES];
    logic [COUNT_W-1:0] managed_frames = MANAGED_RESET;
    grant_t             expected_grants [$];
    request_row_t       directed_rows [DIRECTED_ROWS];
    logic [COUNT_W-1:0] phase_limits [PHASES];
    bit                 steady_phase = 1'b0;
    int                 mismatch_count = 0;
    int                 grant_count = 0;
    int                 refused_count = 0;
    int                 request_count = 0;

    page_frame_bitmap_allocator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    // set or clear a run, frames past the map are dropped
    function automatic void mark_run(input int first, input int n, input bit used);
        int f;
        for (f = first; f < first + n && f < CAP_FRAMES; f++)
            frame_busy[f] = used;
    endfunction

    // carry out one request on the bench bitmap and return its result
    function automatic grant_t serve_request(input mode_t mode,
                                             input logic [FRAME_W-1:0] start,
                                             input logic [COUNT_W-1:0] count);
        grant_t g;
        int     bound;
        int     f;
        int     first;
        int     run;
        g = '0;
        first = 0;
        run = 0;
        bound = managed_frames;
        if (bound > CAP_FRAMES)
            bound = CAP_FRAMES;
        if (bound > FRAME_LIMIT)
            bound = FRAME_LIMIT;
        case (mode)
            MODE_ALLOC_RUN:
                if (count != 0)
                    for (f = 0; f < bound && !g.ok; f++)
                    begin
                        if (frame_busy[f])
                            run = 0;
                        else
                        begin
                            if (run == 0)
                                first = f;
                            run++;
                            if (run == count)
                            begin
                                mark_run(first, count, 1'b1);
                                g.frame = first[FRAME_W-1:0];
                                g.ok = 1'b1;
                            end
                        end
                    end
            MODE_ALLOC_ONE:
                for (f = 0; f < bound && !g.ok; f++)
                    if (!frame_busy[f])
                    begin
                        frame_busy[f] = 1'b1;
                        g.frame = f[FRAME_W-1:0];
                        g.ok = 1'b1;
                    end
            default:
            begin
                // free and reserve always succeed and echo the start
                mark_run(start, count, mode == MODE_RESERVE_RUN);
                g.frame = start;
                g.ok = 1'b1;
            end
        endcase
        return g;
    endfunction

    // random request, starts mostly around the searched area
    function automatic request_row_t random_request();
        request_row_t row;
        int           pick;
        int           span;
        row = '0;
        pick = $urandom_range(99);
        if (pick < 40)
            row.mode = MODE_ALLOC_RUN;
        else if (pick < 60)
            row.mode = MODE_ALLOC_ONE;
        else if (pick < 85)
            row.mode = MODE_FREE_RUN;
        else
            row.mode = MODE_RESERVE_RUN;
        span = (managed_frames > FRAME_LIMIT) ? FRAME_LIMIT : managed_frames;
        span = span + 64;
        if (span > 65535)
            span = 65535;
        if ($urandom_range(99) < 70)
            row.start = FRAME_W'($urandom_range(0, span));
        else
            row.start = FRAME_W'($urandom_range(0, 65535));
        pick = $urandom_range(99);
        if (pick < 70)
            row.count = COUNT_W'($urandom_range(1, 8));
        else if (pick < 88)
            row.count = COUNT_W'($urandom_range(9, 80));
        else if (pick < 93)
            row.count = '0;
        else if (row.mode == MODE_RESERVE_RUN)
            row.count = COUNT_W'($urandom_range(81, 300));   // keep the map from filling up
        else if (pick < 97)
            row.count = COUNT_W'($urandom_range(0, 17'h1FFFF));
        else
            row.count = $urandom_range(0, 1) ? 17'h10000 : 17'h1FFFF;
        return row;
    endfunction

    // offer one request, predict it at the edge where it is taken
    task automatic send_request(input request_row_t row);
        grant_t g;
        while (!steady_phase && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, row.count, row.start};
        s_axis_tuser  <= row.mode;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        g = serve_request(row.mode, row.start, row.count);
        if (row.known)
            g = {row.frame, row.ok};
        if (!g.ok)
            refused_count++;
        expected_grants.push_back(g);
        request_count++;
    endtask

    // wait for every outstanding result, block is idle afterwards
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_grants.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_managed(input logic [COUNT_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        managed_frames = value;
    endtask

    // result side: compare, then pick the next ready level
    always @(posedge clk)
    begin : result_check
        grant_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_grants.size() == 0)
            begin
                $display("%0t: result with no request pending, got frame %h ok %b",
                         $time, m_axis_tdata[15:0], m_axis_tdata[16]);
                mismatch_count++;
            end
            else
            begin
                want = expected_grants.pop_front();
                grant_count++;
                if (m_axis_tdata[15:0] !== want.frame)
                begin
                    $display("%0t: frame mismatch, expected %h got %h",
                             $time, want.frame, m_axis_tdata[15:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[16] !== want.ok)
                begin
                    $display("%0t: ok mismatch, expected %b got %b",
                             $time, want.ok, m_axis_tdata[16]);
                    mismatch_count++;
                end
            end
        end
        m_axis_tready <= steady_phase || ($urandom_range(99) >= IDLE_PCT);
    end

    initial
    begin : stimulus
        int i;
        int p;
        // mode, start, count, typed, frame, ok
        directed_rows = '{
            '{MODE_ALLOC_RUN,   16'h0000, 17'd1,       1'b1, 16'h0000, 1'b1}, // frame 0 starts a run
            '{MODE_ALLOC_ONE,   16'h0000, 17'd0,       1'b1, 16'h0001, 1'b1},
            '{MODE_ALLOC_RUN,   16'h1234, 17'd0,       1'b1, 16'h0000, 1'b0}, // zero count fails
            '{MODE_ALLOC_RUN,   16'hFFFF, 17'd5,       1'b1, 16'h0002, 1'b1}, // start ignored
            '{MODE_FREE_RUN,    16'h0001, 17'd1,       1'b1, 16'h0001, 1'b1},
            '{MODE_ALLOC_ONE,   16'hABCD, 17'h1FFFF,   1'b1, 16'h0001, 1'b1}, // count ignored
            '{MODE_RESERVE_RUN, 16'hFFFF, 17'h1FFFF,   1'b1, 16'hFFFF, 1'b1}, // runs off the map
            '{MODE_FREE_RUN,    16'hFFFF, 17'd0,       1'b1, 16'hFFFF, 1'b1}, // empty free
            '{MODE_ALLOC_RUN,   16'h0000, 17'h10000,   1'b1, 16'h0000, 1'b0}, // whole map, no fit
            '{MODE_FREE_RUN,    16'h0000, 17'h10000,   1'b1, 16'h0000, 1'b1},
            '{MODE_ALLOC_RUN,   16'h0000, 17'h10000,   1'b1, 16'h0000, 1'b1}, // whole map fits
            '{MODE_ALLOC_ONE,   16'h0000, 17'd0,       1'b1, 16'h0000, 1'b0}, // map full
            '{MODE_ALLOC_RUN,   16'h0000, 17'h1FFFF,   1'b1, 16'h0000, 1'b0},
            '{MODE_FREE_RUN,    16'h8000, 17'd64,      1'b1, 16'h8000, 1'b1},
            '{MODE_ALLOC_RUN,   16'h0000, 17'd64,      1'b1, 16'h8000, 1'b1}, // one full word
            '{MODE_FREE_RUN,    16'h0064, 17'd3,       1'b1, 16'h0064, 1'b1},
            '{MODE_ALLOC_RUN,   16'h0000, 17'd4,       1'b1, 16'h0000, 1'b0}, // hole too short
            '{MODE_ALLOC_RUN,   16'h0000, 17'd3,       1'b1, 16'h0064, 1'b1}, // exact fit
            '{MODE_FREE_RUN,    16'h0000, 17'h1FFFF,   1'b1, 16'h0000, 1'b1},
            '{MODE_RESERVE_RUN, 16'h0000, 17'd63,      1'b1, 16'h0000, 1'b1},
            '{MODE_ALLOC_RUN,   16'h0000, 17'd2,       1'b1, 16'h003F, 1'b1}, // crosses a word
            '{MODE_ALLOC_ONE,   16'h0000, 17'd0,       1'b1, 16'h0041, 1'b1},
            '{MODE_RESERVE_RUN, 16'hFFC0, 17'd64,      1'b1, 16'hFFC0, 1'b1}, // last word
            '{MODE_ALLOC_RUN,   16'h5555, 17'h0AAAA,   1'b0, 16'h0000, 1'b0}
        };
        // reset value first, small bounds keep the scans short
        phase_limits = '{17'd65536, 17'd256, 17'd0, 17'd1, 17'h1FFFF,
                         17'd1000, 17'd65535, 17'd4096, 17'd64, 17'd70};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed part runs with the reset value of managed_frames
        for (i = 0; i < DIRECTED_ROWS; i++)
            send_request(directed_rows[i]);

        for (p = 0; p < PHASES; p++)
        begin
            drain_results();
            write_managed(phase_limits[p]);
            steady_phase = (p == 4);   // one phase with no gaps on either side
            for (i = 0; i < PHASE_ITEMS; i++)
                send_request(random_request());
        end
        steady_phase = 1'b0;

        drain_results();
        repeat (50) @(posedge clk);

        $display("%0d requests sent: %0d table rows, %0d random over %0d register settings",
                 request_count, DIRECTED_ROWS, request_count - DIRECTED_ROWS, PHASES);
        $display("%0d results checked, %0d of them refused allocations",
                 grant_count, refused_count);
        if (mismatch_count == 0 && expected_grants.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #20000000;
        $display("timed out with %0d results outstanding", expected_grants.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/pfba_pkg.sv
sv/pfba_map_ram.sv
sv/pfba_word_scan.sv
sv/pfba_run_mask.sv
sv/page_frame_bitmap_allocator.sv
verif/tb.sv
